// ===== rtl/core/tccs_pkg.sv =====
// Shared types, geometry constants and command codes of the text console block.
package tccs_pkg;

  localparam int unsigned CHARS_PER_LINE = 64;
  localparam int unsigned SCREEN_LINES   = 32;
  localparam int unsigned PAGES          = 4;

  localparam int unsigned STORE_SIZE     = CHARS_PER_LINE * SCREEN_LINES * PAGES;
  localparam int unsigned VIEW_TOP_LIMIT = SCREEN_LINES * (PAGES - 1);

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned LINE_W = 5;
  localparam int unsigned VT_W   = 7;
  localparam int unsigned ADDR_W = 13;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT  = 2'd0,
    CMD_READ = 2'd1,
    CMD_HOME = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  read_col;
    logic [LINE_W-1:0] read_line;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cell_addr;
    logic              cell_written;
    logic [CHAR_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_col_out;
    logic [LINE_W-1:0] cursor_line_out;
    logic [VT_W-1:0]   view_top_out;
    logic              scrolled;
  } out_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== rtl/core/tccs_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module tccs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tccs_cursor.sv =====
// Cursor and view registers with the per-request update and store access request.
module tccs_cursor import tccs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_t      req_i,
  output mem_req_t mem_o,
  output out_t     res_o
);

  localparam logic [COL_W-1:0]  ColLast  = COL_W'(CHARS_PER_LINE - 1);
  localparam logic [LINE_W-1:0] LineLast = LINE_W'(SCREEN_LINES - 1);
  localparam logic [VT_W-1:0]   VtLimit  = VT_W'(VIEW_TOP_LIMIT);

  logic [COL_W-1:0]  col_q, col_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [VT_W-1:0]   vt_q, vt_d;

  logic              at_last_line;
  logic              at_last_col;
  logic              can_scroll;
  logic [COL_W-1:0]  bs_col;
  logic [LINE_W-1:0] bs_line;
  logic [COL_W-1:0]  acc_col;
  logic [LINE_W-1:0] acc_line;
  logic [ADDR_W-1:0] row;
  logic              scrolled;

  assign at_last_line = (line_q == LineLast);
  assign at_last_col  = (col_q == ColLast);
  assign can_scroll   = (vt_q < VtLimit);

  // Backspace target: step left, wrap to end of previous line, stick at origin.
  always_comb begin
    bs_col  = col_q;
    bs_line = line_q;
    if (col_q != '0) begin
      bs_col = col_q - COL_W'(1);
    end else if (line_q != '0) begin
      bs_col  = ColLast;
      bs_line = line_q - LINE_W'(1);
    end
  end

  always_comb begin
    col_d    = col_q;
    line_d   = line_q;
    vt_d     = vt_q;
    scrolled = 1'b0;
    acc_col  = col_q;
    acc_line = line_q;
    mem_o    = '0;
    unique case (req_i.command)
      CMD_PUT: begin
        mem_o.we = 1'b1;
        if (req_i.char_code == CODE_NEWLINE) begin
          mem_o.wdata = req_i.char_code;
          col_d       = '0;
          if (!at_last_line) begin
            line_d = line_q + LINE_W'(1);
          end else if (can_scroll) begin
            vt_d     = vt_q + VT_W'(1);
            scrolled = 1'b1;
          end
        end else if (req_i.char_code == CODE_BACKSPACE) begin
          col_d       = bs_col;
          line_d      = bs_line;
          acc_col     = bs_col;
          acc_line    = bs_line;
          mem_o.wdata = '0;
        end else begin
          mem_o.wdata = req_i.char_code;
          if (!at_last_col) begin
            col_d = col_q + COL_W'(1);
          end else if (!at_last_line) begin
            col_d  = '0;
            line_d = line_q + LINE_W'(1);
          end else if (can_scroll) begin
            // Last cell of the last line: hold the cursor there, scroll if room.
            vt_d     = vt_q + VT_W'(1);
            scrolled = 1'b1;
          end
        end
      end
      CMD_READ: begin
        mem_o.re = 1'b1;
        acc_col  = req_i.read_col;
        acc_line = req_i.read_line;
      end
      CMD_HOME: begin
        col_d  = '0;
        line_d = '0;
      end
      default: begin
      end
    endcase
    row = ADDR_W'(vt_q) + ADDR_W'(acc_line);
    if (mem_o.we || mem_o.re) begin
      mem_o.addr = ADDR_W'(row * ADDR_W'(CHARS_PER_LINE)) + ADDR_W'(acc_col);
    end
  end

  always_comb begin
    res_o                 = '0;
    res_o.cell_addr       = mem_o.addr;
    res_o.cell_written    = mem_o.we;
    res_o.cell_data       = mem_o.wdata;
    res_o.cursor_col_out  = col_d;
    res_o.cursor_line_out = line_d;
    res_o.view_top_out    = vt_d;
    res_o.scrolled        = scrolled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      line_q <= '0;
      vt_q   <= '0;
    end else if (accept_i) begin
      col_q  <= col_d;
      line_q <= line_d;
      vt_q   <= vt_d;
    end
  end

endmodule

// ===== rtl/core/text_console_cursor_scrollback.sv =====
// A request is registered in stage s1, where store read data joins it, then in
// the output register. Throughput: one request per cycle when not stalled.
// Each PUT or READ request takes one access of the character store.
// A stalled output holds the result register and the stage behind it.
// Reset clears cursor and view at once, then sweeps the 8192-entry store
// to zero, one entry per cycle; no request is accepted during that sweep.
module text_console_cursor_scrollback import tccs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam logic [ADDR_W-1:0] ClrLast = ADDR_W'(STORE_SIZE - 1);

  logic              clr_busy_q, clr_busy_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  logic              s1_valid_q, s1_valid_d;
  out_t              s1_res_q;
  logic              s1_rd_q;
  logic              out_valid_q, out_valid_d;
  out_t              out_q;

  logic              accept;
  logic              out_go;
  logic              s1_free;
  mem_req_t          mem;
  out_t              res;
  out_t              s1_out;
  logic [CHAR_W-1:0] rdata;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;

  assign out_go     = !out_valid_q || out_ready_i;
  assign s1_free    = !s1_valid_q || out_go;
  assign in_ready_o = !clr_busy_q && s1_free;
  assign accept     = in_valid_i && in_ready_o;

  tccs_cursor u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (in_data_i),
    .mem_o    (mem),
    .res_o    (res)
  );

  // Clear sweep owns the write port until it finishes.
  assign ram_we    = clr_busy_q || (accept && mem.we);
  assign ram_waddr = clr_busy_q ? clr_cnt_q : mem.addr;
  assign ram_wdata = clr_busy_q ? '0 : mem.wdata;

  tccs_ram #(
    .Width (CHAR_W),
    .Depth (STORE_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept && mem.re),
    .raddr_i (mem.addr),
    .rdata_o (rdata)
  );

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ClrLast) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  // Read data arrives from the store in the cycle after the access.
  always_comb begin
    s1_out = s1_res_q;
    if (s1_rd_q) begin
      s1_out.cell_data = rdata;
    end
  end

  assign s1_valid_d  = s1_free ? accept : s1_valid_q;
  assign out_valid_d = out_go ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
      s1_rd_q  <= mem.re;
    end
    if (out_go && s1_valid_q) begin
      out_q <= s1_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("request accepted during store clear");

  a_scroll_on_last_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.scrolled) |->
      (out_data_o.cursor_line_out == LINE_W'(SCREEN_LINES - 1)))
    else $error("scroll reported with cursor off the last line");

  a_view_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.view_top_out <= VT_W'(VIEW_TOP_LIMIT)))
    else $error("view top past last page");

  a_s1_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_go) |=> (s1_valid_q && $stable(s1_res_q) && $stable(rdata)))
    else $error("pending stage changed under output stall");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the text console with cursor and scrollback store.
module testbench;
  import tccs_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_PER_PHASE = 345;
  localparam int HOLD_CYCLES      = 300;
  localparam int REPORT_LIMIT     = 10;
  localparam int DRAIN_GUARD      = 50000;

  class console_scoreboard;
    bit [CHAR_W-1:0] chars [STORE_SIZE];
    int unsigned cur_col    = 0;
    int unsigned cur_line   = 0;
    int unsigned view_top   = 0;
    int unsigned failures   = 0;
    int unsigned mismatches = 0;
    out_t        expected_q [$];

    function int unsigned cell_index(int unsigned col, int unsigned row);
      return ((view_top + row) * CHARS_PER_LINE + col) % STORE_SIZE;
    endfunction

    // Step to the next line; at the bottom, scroll while store lines remain.
    function bit line_down();
      if (cur_line + 1 < SCREEN_LINES) begin
        cur_line++;
        return 1'b0;
      end
      cur_line = SCREEN_LINES - 1;
      if (view_top < VIEW_TOP_LIMIT) begin
        view_top++;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function out_t console_step(in_t req);
      out_t        res;
      int unsigned addr;
      res  = '0;
      addr = 0;
      case (req.command)
        CMD_PUT: begin
          res.cell_written = 1'b1;
          if (req.char_code == CODE_NEWLINE) begin
            addr = cell_index(cur_col, cur_line);
            chars[addr] = req.char_code;
            res.cell_data = req.char_code;
            cur_col = 0;
            res.scrolled = line_down();
          end else if (req.char_code == CODE_BACKSPACE) begin
            if (cur_col > 0) begin
              cur_col--;
            end else if (cur_line > 0) begin
              cur_col = CHARS_PER_LINE - 1;
              cur_line--;
            end
            addr = cell_index(cur_col, cur_line);
            chars[addr] = '0;
          end else begin
            addr = cell_index(cur_col, cur_line);
            chars[addr] = req.char_code;
            res.cell_data = req.char_code;
            if (cur_col + 1 < CHARS_PER_LINE) begin
              cur_col++;
            end else begin
              // on the last line the cursor sticks at the last column
              cur_col = (cur_line + 1 < SCREEN_LINES) ? 0 : CHARS_PER_LINE - 1;
              res.scrolled = line_down();
            end
          end
          res.cell_addr = addr[ADDR_W-1:0];
        end
        CMD_READ: begin
          addr = cell_index(req.read_col, req.read_line);
          res.cell_addr = addr[ADDR_W-1:0];
          res.cell_data = chars[addr];
        end
        CMD_HOME: begin
          cur_col  = 0;
          cur_line = 0;
        end
        default: ;
      endcase
      res.cursor_col_out  = cur_col[COL_W-1:0];
      res.cursor_line_out = cur_line[LINE_W-1:0];
      res.view_top_out    = view_top[VT_W-1:0];
      return res;
    endfunction

    function void note_request(in_t req);
      expected_q.push_back(console_step(req));
    endfunction

    function string fmt_result(out_t r);
      return $sformatf("addr=%0d wr=%0d data=%02h col=%0d line=%0d top=%0d scr=%0d",
                       r.cell_addr, r.cell_written, r.cell_data, r.cursor_col_out,
                       r.cursor_line_out, r.view_top_out, r.scrolled);
    endfunction

    function void check_result(out_t got);
      out_t want;
      bit   bad;
      if (expected_q.size() == 0) begin
        failures++;
        if (mismatches < REPORT_LIMIT)
          $display("unexpected result: %s", fmt_result(got));
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      bad = (got.cell_addr       !== want.cell_addr)       ||
            (got.cell_written    !== want.cell_written)    ||
            (got.cell_data       !== want.cell_data)       ||
            (got.cursor_col_out  !== want.cursor_col_out)  ||
            (got.cursor_line_out !== want.cursor_line_out) ||
            (got.view_top_out    !== want.view_top_out)    ||
            (got.scrolled        !== want.scrolled);
      if (bad) begin
        failures++;
        if (mismatches < REPORT_LIMIT) begin
          $display("mismatch expected: %s", fmt_result(want));
          $display("mismatch actual:   %s", fmt_result(got));
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  console_scoreboard sb;

  text_console_cursor_scrollback u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic in_t console_req(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] code,
                                      logic [COL_W-1:0] col, logic [LINE_W-1:0] row);
    in_t req;
    req.command   = cmd;
    req.char_code = code;
    req.read_col  = col;
    req.read_line = row;
    return req;
  endfunction

  // Mostly text with newlines at a burst-dependent rate; home only once the
  // view has scrolled all the way, so the scrollback limit is reached first.
  function automatic in_t random_console_req(int nl_pct);
    in_t         req;
    int unsigned pick;
    int unsigned home_pct;
    req = console_req(CMD_PUT, 8'($urandom_range(255)), 6'($urandom_range(63)),
                      5'($urandom_range(31)));
    home_pct = (sb.view_top == VIEW_TOP_LIMIT) ? 3 : 0;
    pick = $urandom_range(99);
    if (pick < 2) begin
      req.command = CMD_UNUSED;
    end else if (pick < 2 + home_pct) begin
      req.command = CMD_HOME;
    end else if (pick < 22 + home_pct) begin
      req.command = CMD_READ;
      if ($urandom_range(1)) req.read_line = sb.cur_line[LINE_W-1:0];
    end else begin
      pick = $urandom_range(99);
      if (pick < nl_pct) req.char_code = CODE_NEWLINE;
      else if (pick < nl_pct + 8) req.char_code = CODE_BACKSPACE;
      else if (pick < 90) req.char_code = 8'($urandom_range(126, 32));
    end
    return req;
  endfunction

  task automatic offer(in_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(req);
  endtask

  task automatic wait_for_drain();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  initial begin
    int phase;
    int n;
    int nl_pct;
    sb = new;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    hold_req    = 1'b0;
    tx_idle_pct = 15;
    rx_idle_pct = 61;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners of the screen, erase back to home and past it, newline and backward line wrap
    offer(console_req(CMD_READ, 8'h00, 6'd0, 5'd0));
    offer(console_req(CMD_READ, 8'hFF, 6'd63, 5'd31));
    offer(console_req(CMD_PUT, 8'h00, 6'd0, 5'd0));
    offer(console_req(CMD_PUT, 8'hFF, 6'd0, 5'd0));
    offer(console_req(CMD_PUT, 8'h41, 6'd0, 5'd0));
    repeat (4) offer(console_req(CMD_PUT, CODE_BACKSPACE, 6'd0, 5'd0));
    offer(console_req(CMD_READ, 8'h00, 6'd1, 5'd0));
    offer(console_req(CMD_PUT, CODE_NEWLINE, 6'd0, 5'd0));
    offer(console_req(CMD_PUT, 8'h42, 6'd0, 5'd0));
    offer(console_req(CMD_PUT, CODE_BACKSPACE, 6'd0, 5'd0));
    offer(console_req(CMD_PUT, CODE_BACKSPACE, 6'd0, 5'd0));
    offer(console_req(CMD_READ, 8'h00, 6'd63, 5'd0));
    offer(console_req(CMD_PUT, 8'h7F, 6'd0, 5'd0));
    offer(console_req(CMD_READ, 8'h00, 6'd0, 5'd0));
    offer(console_req(CMD_HOME, 8'hFF, 6'd63, 5'd31));
    offer(console_req(CMD_UNUSED, 8'hFF, 6'd63, 5'd31));

    for (phase = 0; phase < 3; phase++) begin
      wait_for_drain();
      case (phase)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 61;
        end
        1: begin
          tx_idle_pct = 61;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req = 1'b1;
        end
      endcase
      nl_pct = 3;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 40 == 0) nl_pct = $urandom_range(1) ? 30 : 3;
        offer(random_console_req(nl_pct));
      end
    end

    wait_for_drain();
    repeat (4) @(posedge clk_i);
    sb.failures += sb.expected_q.size();
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
